### src/btab_pkg.sv
// ----------------------------------------------------------------------------
// btab_pkg: shared types and constants of the button state table
// Op codes, button state and pending signal codes, cell control and the
// per-tick state update.
// ----------------------------------------------------------------------------
`default_nettype none

package btab_pkg;

  localparam int NUM_INPUTS_DEF = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int OP_W           = 3;
  localparam int INDEX_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PRESS   = 3'd0,
    OP_IMPULSE = 3'd1,
    OP_SET     = 3'd2,
    OP_RELEASE = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASED = 2'd3
  } btn_state_e;

  typedef enum logic [1:0] {
    SIG_NONE    = 2'd0,
    SIG_PRESS   = 2'd1,
    SIG_RELEASE = 2'd2,
    SIG_IMPULSE = 2'd3
  } sig_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_TICK = 1'b1
  } fsm_e;

  // control for one cell of the ring
  typedef struct packed {
    logic shift;
    logic wr;
    op_e  op;
  } cell_ctrl_t;

  typedef struct packed {
    btn_state_e st;
    sig_e       sig;
    logic       clear_value;
  } tick_upd_t;

  // state advance of one entry on a tick
  function automatic tick_upd_t tick_update(btn_state_e st, sig_e sig);
    tick_upd_t r;
    r.st          = st;
    r.sig         = sig;
    r.clear_value = 1'b0;
    case (sig)
      SIG_NONE: begin
        if (st == ST_PRESSED) begin
          r.st = ST_HELD;
        end else if (st == ST_RELEASED) begin
          r.st          = ST_NONE;
          r.clear_value = 1'b1;
        end
      end
      SIG_PRESS: begin
        if (st == ST_NONE || st == ST_RELEASED) r.st = ST_PRESSED;
        r.sig = SIG_NONE;
      end
      SIG_RELEASE: begin
        if (st == ST_PRESSED || st == ST_HELD) r.st = ST_RELEASED;
        r.sig         = SIG_NONE;
        r.clear_value = 1'b1;
      end
      default: begin
        // impulse: pressed now, release on the next tick
        r.st  = ST_PRESSED;
        r.sig = SIG_RELEASE;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/btab_req_if.sv
// ----------------------------------------------------------------------------
// btab_req_if: event channel of the button state table
// Valid/ready channel carrying op, input_index and new_value.
// ----------------------------------------------------------------------------
`default_nettype none

interface btab_req_if
  import btab_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              op;
  logic [INDEX_W-1:0]           input_index;
  logic signed [VALUE_BITS-1:0] new_value;

  modport source (output valid, output op, output input_index, output new_value,
                  input ready);
  modport sink   (input valid, input op, input input_index, input new_value,
                  output ready);
endinterface

`default_nettype wire

### src/btab_rsp_if.sv
// ----------------------------------------------------------------------------
// btab_rsp_if: result channel of the button state table
// Valid/ready channel carrying one reported entry per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface btab_rsp_if
  import btab_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [INDEX_W-1:0]           entry_index;
  logic [1:0]                   button_state;
  logic signed [VALUE_BITS-1:0] entry_value;
  logic                         last_of_run;

  modport source (output valid, output entry_index, output button_state,
                  output entry_value, output last_of_run, input ready);
  modport sink   (input valid, input entry_index, input button_state,
                  input entry_value, input last_of_run, output ready);
endinterface

`default_nettype wire

### src/btab_cell.sv
// ----------------------------------------------------------------------------
// btab_cell: one entry of the button table ring
// Holds state, pending signal and value; takes an event write in place or
// the neighbor's entry when the ring shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module btab_cell
  import btab_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cell_ctrl_t                   ctrl,
  input  wire logic signed [VALUE_BITS-1:0] wr_value,
  input  wire btn_state_e                   st_in,
  input  wire sig_e                         sig_in,
  input  wire logic signed [VALUE_BITS-1:0] val_in,
  output btn_state_e                        st,
  output sig_e                              sig,
  output logic signed [VALUE_BITS-1:0]      val
);

  btn_state_e                   st_next;
  sig_e                         sig_next;
  logic signed [VALUE_BITS-1:0] val_next;

  // shift from neighbor, or apply an event in place
  always_comb begin
    st_next  = st;
    sig_next = sig;
    val_next = val;
    if (ctrl.shift) begin
      st_next  = st_in;
      sig_next = sig_in;
      val_next = val_in;
    end else if (ctrl.wr) begin
      case (ctrl.op)
        OP_PRESS: begin
          sig_next = SIG_PRESS;
          val_next = wr_value;
        end
        OP_IMPULSE: begin
          sig_next = SIG_IMPULSE;
          val_next = wr_value;
        end
        OP_SET: begin
          st_next  = ST_NONE;
          sig_next = SIG_NONE;
          val_next = wr_value;
        end
        OP_RELEASE: begin
          sig_next = SIG_RELEASE;
          val_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_NONE;
      sig <= SIG_NONE;
      val <= '0;
    end else begin
      st  <= st_next;
      sig <= sig_next;
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

### src/button_state_table_core.sv
// ----------------------------------------------------------------------------
// button_state_table_core: press / hold / release tracker for logical inputs
// Ring of entry cells with event writes and a rotating tick walk.
// ----------------------------------------------------------------------------
// Usage:
//   req carries events (press, impulse, set value, release) and ticks.
//   rsp carries reported entries, last_of_run marks the final beat of an item.
//   An event writes the addressed cell, and its entry, after the update,
//   goes to the output register in the same cycle, so the result is on
//   rsp in the cycle after acceptance.
//   A tick rotates the cell ring once: each cycle that rsp does not stall,
//   the entry at the head is advanced, written into the tail and sent out.
//   The accept moves the FSM into S_TICK, and the beats are loaded into the
//   output register from there; req is not ready during the walk.
//   Ops 5 to 7 are accepted and give no beat.
//   Throughput: one event per cycle while rsp does not stall; a tick holds
//   off new items until the ring has rotated once.
//   When rsp stalls, the output register holds and the ring stops shifting;
//   a new item is taken only when the output register can take its result.
//   Synchronous reset clears every entry to state none, no signal, value 0.
// ----------------------------------------------------------------------------
`default_nettype none

module button_state_table_core
  import btab_pkg::*;
#(
  parameter int NUM_INPUTS = NUM_INPUTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  btab_req_if.sink  req,
  btab_rsp_if.source rsp
);

  localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

  // ring storage views
  btn_state_e                   cell_st  [NUM_INPUTS];
  sig_e                         cell_sig [NUM_INPUTS];
  logic signed [VALUE_BITS-1:0] cell_val [NUM_INPUTS];

  fsm_e              state, state_next;
  logic [IDX_W-1:0]  cnt;
  logic              slot_free;
  logic              advance;
  logic              accept;
  logic              is_event;
  logic              in_range;
  logic              cnt_last;
  logic [31:0]       idx_ext;
  logic [31:0]       cnt_ext;
  op_e               req_op;

  // output register
  logic                         out_valid;
  logic [INDEX_W-1:0]           out_index;
  btn_state_e                   out_st;
  logic signed [VALUE_BITS-1:0] out_val;
  logic                         out_last;

  // head of ring after the tick update
  tick_upd_t                    head_upd;
  logic signed [VALUE_BITS-1:0] head_val;

  assign req_op    = op_e'(req.op);
  assign slot_free = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_event  = (req_op == OP_PRESS) || (req_op == OP_IMPULSE) ||
                     (req_op == OP_SET) || (req_op == OP_RELEASE);
  assign idx_ext   = 32'(req.input_index);
  assign in_range  = idx_ext < 32'(NUM_INPUTS);
  assign cnt_ext   = 32'(cnt);
  assign cnt_last  = cnt_ext == 32'(NUM_INPUTS - 1);

  assign head_upd  = tick_update(cell_st[0], cell_sig[0]);
  assign head_val  = head_upd.clear_value ? '0 : cell_val[0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && req_op == OP_TICK) state_next = S_TICK;
      S_TICK: if (advance && cnt_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    req.ready = 1'b0;
    advance   = 1'b0;
    case (state)
      S_IDLE:  req.ready = slot_free;
      S_TICK:  advance   = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
    end
  end

  // cell ring: cell i takes from cell i+1, the tail takes the updated head
  for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_cell
    cell_ctrl_t                   ctrl;
    btn_state_e                   nb_st;
    sig_e                         nb_sig;
    logic signed [VALUE_BITS-1:0] nb_val;

    assign ctrl.shift = advance;
    assign ctrl.wr    = accept && is_event && in_range && (idx_ext == 32'(i));
    assign ctrl.op    = req_op;

    if (i == NUM_INPUTS - 1) begin : g_tail
      assign nb_st  = head_upd.st;
      assign nb_sig = head_upd.sig;
      assign nb_val = head_val;
    end else begin : g_body
      assign nb_st  = cell_st[i+1];
      assign nb_sig = cell_sig[i+1];
      assign nb_val = cell_val[i+1];
    end

    btab_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .wr_value(req.new_value),
      .st_in   (nb_st),
      .sig_in  (nb_sig),
      .val_in  (nb_val),
      .st      (cell_st[i]),
      .sig     (cell_sig[i]),
      .val     (cell_val[i])
    );
  end

  // output register: event result or tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (accept && is_event) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index <= cnt_ext[INDEX_W-1:0];
      out_st    <= head_upd.st;
      out_val   <= head_val;
      out_last  <= cnt_last;
    end else if (accept && is_event) begin
      out_index <= req.input_index;
      out_last  <= 1'b1;
      if (!in_range) begin
        out_st  <= ST_NONE;
        out_val <= '0;
      end else begin
        out_st  <= (req_op == OP_SET) ? ST_NONE : cell_st[idx_ext[IDX_W-1:0]];
        out_val <= (req_op == OP_RELEASE) ? '0 : req.new_value;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.entry_index  = out_index;
  assign rsp.button_state = out_st;
  assign rsp.entry_value  = out_val;
  assign rsp.last_of_run  = out_last;

  // no new item while the ring rotates
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_TICK |-> !req.ready)
    else $error("item taken during tick walk");

  // the final tick beat ends the walk
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK && advance && cnt_last) |=> (state == S_IDLE && rsp.last_of_run))
    else $error("tick walk did not end on last beat");

  // an accepted event gives a single final beat next cycle
  a_event_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && is_event) |=> (rsp.valid && rsp.last_of_run))
    else $error("event result missing");

endmodule

`default_nettype wire
